[rtl/rrl_pkg.sv]
// Shared types and constants of the repeat request limiter.
// Entry layout, cell operations, register map and head control/result bundles.
// No dependencies.
package rrl_pkg;

  localparam int ENTRIES   = 30;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int KEY_W     = 32;
  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_WINDOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_CAP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REJECT       = 3'd4;

  localparam logic [TIME_W-1:0]  RST_CLEAR_PERIOD = TIME_W'(60 * 60 * 1000);
  localparam logic [TIME_W-1:0]  RST_KEEP_WINDOW  = TIME_W'(10 * 60 * 1000);
  localparam logic [COUNT_W-1:0] RST_KEEP_MIN     = COUNT_W'(75);
  localparam logic [COUNT_W-1:0] RST_KEEP_CAP     = COUNT_W'(99);
  localparam logic [COUNT_W-1:0] RST_REJECT       = COUNT_W'(105);

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  stamp;
  } entry_t;

  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_TAKE_RIGHT = 3'd1,
    OP_SWAP_LO    = 3'd2,
    OP_SWAP_HI    = 3'd3,
    OP_LOAD_NEW   = 3'd4
  } cell_op_t;

  typedef struct packed {
    logic [TIME_W-1:0]  clear_period;
    logic [TIME_W-1:0]  keep_window;
    logic [COUNT_W-1:0] keep_min;
    logic [COUNT_W-1:0] keep_cap;
    logic [COUNT_W-1:0] reject;
  } cfg_t;

  typedef struct packed {
    logic             sweep;
    logic             search;
    logic [IDX_W-1:0] pos;
  } head_ctrl_t;

  typedef struct packed {
    logic              hit;
    logic              allowed;
    logic [TIME_W-1:0] since;
    logic [IDX_W-1:0]  victim;
    logic [CNT_W-1:0]  used;
  } head_res_t;

endpackage

[rtl/rrl_cell.sv]
// One table entry of the limiter chain.
// Shifts, compacts or loads according to the op from the sequencer.
// Depends on rrl_pkg.
module rrl_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  rrl_pkg::cell_op_t op,
  input  rrl_pkg::entry_t   left_in,
  input  rrl_pkg::entry_t   right_in,
  input  rrl_pkg::entry_t   new_in,
  output rrl_pkg::entry_t   entry_q
);
  import rrl_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    case (op)
      OP_TAKE_RIGHT: entry_nxt = right_in;
      // odd-even compaction: valid entries move toward cell 0, order kept
      OP_SWAP_LO: begin
        if (!entry_r.valid && right_in.valid) entry_nxt = right_in;
      end
      OP_SWAP_HI: begin
        if (!left_in.valid && entry_r.valid) entry_nxt = left_in;
      end
      OP_LOAD_NEW:   entry_nxt = new_in;
      default:       entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry_q = entry_r;

endmodule

[rtl/rrl_head.sv]
// Processing head at the exit of the rotating chain.
// Prunes entries and caps counts on a sweep pass; on a search pass updates a hit and
// tracks the eviction victim and fill count. Depends on rrl_pkg.
module rrl_head (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rrl_pkg::head_ctrl_t          ctrl,
  input  rrl_pkg::cfg_t                cfg,
  input  logic [rrl_pkg::KEY_W-1:0]    key,
  input  logic [rrl_pkg::TIME_W-1:0]   now,
  input  rrl_pkg::entry_t              entry_in,
  output rrl_pkg::entry_t              entry_out,
  output rrl_pkg::head_res_t           res
);
  import rrl_pkg::*;

  logic [TIME_W-1:0]  age;
  logic               match;
  logic [COUNT_W-1:0] cnt_inc;
  head_res_t          res_r;
  head_res_t          res_nxt;
  logic [TIME_W-1:0]  vage_r;
  logic [TIME_W-1:0]  vage_nxt;
  logic               first;

  assign age     = now - entry_in.stamp;
  assign match   = entry_in.valid && (entry_in.key == key);
  assign cnt_inc = (entry_in.count == {COUNT_W{1'b1}}) ? entry_in.count
                                                        : entry_in.count + 1'b1;
  assign first   = (ctrl.pos == '0);

  always_comb begin
    entry_out = entry_in;
    if (ctrl.sweep) begin
      if (!(age <= cfg.keep_window && entry_in.count >= cfg.keep_min)) begin
        entry_out.valid = 1'b0;
      end
      if (entry_in.count > cfg.keep_cap) entry_out.count = cfg.keep_cap;
    end
    if (ctrl.search && match) begin
      entry_out.count = cnt_inc;
      entry_out.stamp = now;
    end
  end

  always_comb begin
    res_nxt  = res_r;
    vage_nxt = vage_r;
    if (ctrl.search) begin
      if (first) begin
        res_nxt.hit     = 1'b0;
        res_nxt.allowed = 1'b1;
        res_nxt.since   = '0;
        res_nxt.used    = '0;
      end
      if (match) begin
        res_nxt.hit     = 1'b1;
        res_nxt.since   = age;
        res_nxt.allowed = !(cnt_inc > cfg.reject);
      end
      // strict compare keeps the earliest entry on equal age
      if (first || age > vage_r) begin
        res_nxt.victim = ctrl.pos;
        vage_nxt       = age;
      end
      res_nxt.used = res_nxt.used + CNT_W'(entry_in.valid);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vage_r <= vage_nxt;
  end

  assign res = res_r;

endmodule

[rtl/repeat_request_limiter_unit.sv]
// Repeat request limiter: a chain of entry cells with a processing head.
// Depends on rrl_pkg, rrl_cell and rrl_head.
//
// Usage: requests enter on in_* (key hash, time in ms, enable) and one
// result leaves on out_* (allowed, found, time since last use) per request.
// The block holds one request at a time. A disabled request goes straight
// to the done state. An enabled one rotates the 30-entry chain once
// through the head to search; when a sweep is due it first rotates once
// to prune and runs a pass of odd-even compaction. One entry per cycle
// passes the head on each pass. The block returns to idle as the result
// is loaded into the output register; a stalled receiver holds the block
// only once a second result is ready. Reset empties the table, clears the
// last sweep time and loads the default register values. Registers must
// be written through cfg_* while the block is idle; the block itself does
// not enforce this.
module repeat_request_limiter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [71:0]                    in_tdata,   // key_hash, now_ms, limit_enabled
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [39:0]                    out_tdata,  // allowed, was_found, since_last_ms
  input  logic                           cfg_we,
  input  logic [rrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrl_pkg::CFG_W-1:0]      cfg_wdata
);
  import rrl_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SWEEP  = 6'b000010,
    S_PACK   = 6'b000100,
    S_SEARCH = 6'b001000,
    S_INSERT = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  cfg_t              cfg_r;
  logic [KEY_W-1:0]  key_r;
  logic [TIME_W-1:0] now_r;
  logic              dis_r;
  logic [TIME_W-1:0] last_sweep_r;
  logic              out_valid_r;
  logic              out_allowed_r;
  logic              out_found_r;
  logic [TIME_W-1:0] out_since_r;

  logic              in_acc;
  logic [KEY_W-1:0]  in_key;
  logic [TIME_W-1:0] in_now;
  logic              in_en;
  logic              sweep_due;
  logic              pass_end;
  logic              out_load;

  entry_t            cell_q  [ENTRIES];
  cell_op_t          cell_op [ENTRIES];
  entry_t            head_out;
  entry_t            new_entry;
  head_ctrl_t        head_ctrl;
  head_res_t         res;
  logic [ENTRIES-1:0] valid_vec;

  assign in_key    = in_tdata[31:0];
  assign in_now    = in_tdata[63:32];
  assign in_en     = in_tdata[64];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign sweep_due = (in_now - last_sweep_r) >= cfg_r.clear_period;
  assign pass_end  = (cnt_r == IDX_W'(ENTRIES - 1));
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  assign new_entry = '{valid: 1'b1, key: key_r, count: COUNT_W'(1), stamp: now_r};

  assign head_ctrl.sweep  = (state_r == S_SWEEP);
  assign head_ctrl.search = (state_r == S_SEARCH);
  assign head_ctrl.pos    = cnt_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clear_period <= RST_CLEAR_PERIOD;
      cfg_r.keep_window  <= RST_KEEP_WINDOW;
      cfg_r.keep_min     <= RST_KEEP_MIN;
      cfg_r.keep_cap     <= RST_KEEP_CAP;
      cfg_r.reject       <= RST_REJECT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLEAR_PERIOD: cfg_r.clear_period <= cfg_wdata;
        REG_KEEP_WINDOW:  cfg_r.keep_window  <= cfg_wdata;
        REG_KEEP_MIN:     cfg_r.keep_min     <= cfg_wdata[COUNT_W-1:0];
        REG_KEEP_CAP:     cfg_r.keep_cap     <= cfg_wdata[COUNT_W-1:0];
        REG_REJECT:       cfg_r.reject       <= cfg_wdata[COUNT_W-1:0];
        default:          ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) begin
          if (!in_en)         state_nxt = S_DONE;
          else if (sweep_due) state_nxt = S_SWEEP;
          else                state_nxt = S_SEARCH;
        end
      end
      S_SWEEP, S_PACK, S_SEARCH: begin
        cnt_nxt = pass_end ? '0 : cnt_r + 1'b1;
        if (pass_end) begin
          case (state_r)
            S_SWEEP: state_nxt = S_PACK;
            S_PACK:  state_nxt = S_SEARCH;
            default: state_nxt = S_INSERT;
          endcase
        end
      end
      S_INSERT: state_nxt = S_DONE;
      S_DONE:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      last_sweep_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (in_acc && in_en && sweep_due) last_sweep_r <= in_now;
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r <= in_key;
      now_r <= in_now;
      dis_r <= !in_en;
    end
    if (out_load) begin
      out_allowed_r <= dis_r ? 1'b1 : res.allowed;
      out_found_r   <= dis_r ? 1'b0 : res.hit;
      out_since_r   <= dis_r ? '0   : res.since;
    end
  end

  // per-cell operations
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      cell_op[i] = OP_HOLD;
      case (state_r)
        S_SWEEP, S_SEARCH: cell_op[i] = OP_TAKE_RIGHT;
        S_PACK: begin
          if ((i % 2) == int'(cnt_r[0])) begin
            if (i < ENTRIES - 1) cell_op[i] = OP_SWAP_LO;
          end else if (i > 0) begin
            cell_op[i] = OP_SWAP_HI;
          end
        end
        S_INSERT: begin
          if (!res.hit) begin
            if (res.used != CNT_W'(ENTRIES)) begin
              if (CNT_W'(i) == res.used) cell_op[i] = OP_LOAD_NEW;
            end else if (i == ENTRIES - 1) begin
              cell_op[i] = OP_LOAD_NEW;
            end else if (IDX_W'(i) >= res.victim) begin
              cell_op[i] = OP_TAKE_RIGHT;
            end
          end
        end
        default: cell_op[i] = OP_HOLD;
      endcase
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    entry_t left_e, right_e;
    if (g == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_mid_l
      assign left_e = cell_q[g-1];
    end
    if (g == ENTRIES - 1) begin : g_last
      assign right_e = head_out;
    end else begin : g_mid_r
      assign right_e = cell_q[g+1];
    end
    rrl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (cell_op[g]),
      .left_in  (left_e),
      .right_in (right_e),
      .new_in   (new_entry),
      .entry_q  (cell_q[g])
    );
    assign valid_vec[g] = cell_q[g].valid;
  end

  rrl_head u_head (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (head_ctrl),
    .cfg       (cfg_r),
    .key       (key_r),
    .now       (now_r),
    .entry_in  (cell_q[0]),
    .entry_out (head_out),
    .res       (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_since_r, out_found_r, out_allowed_r};

  // table is compacted before every search
  a_compact: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH && cnt_r == '0) |-> (((valid_vec + 1'b1) & valid_vec) == '0))
    else $error("table not compacted at search start");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INSERT && !res.hit) |=>
      ($countones(valid_vec) == ((res.used == CNT_W'(ENTRIES)) ? ENTRIES
                                                               : int'(res.used) + 1)))
    else $error("insert left wrong fill count");

  a_reject_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_allowed_r) |-> out_found_r)
    else $error("reject without a hit");

  a_miss_since: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_since_r == '0))
    else $error("nonzero elapsed time on a miss");

endmodule
